// ===== rtl/apu_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the channel function of the average-predictor pixel unfilter
// no dependencies; imported by apu_pos and the top level

package apu_pkg;

	// register indexes on the configuration port (byte address = 4 * index)
	localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FOUR_CHANNEL = 2'd2;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned ROW_WIDTH_W = 13;
	localparam int unsigned HEIGHT_W = 16;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// position flags that travel with a pixel
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_col;
		logic frame_end;
	} apu_pos_t;

	// one channel: residual plus prediction, mod 256
	function automatic logic [7:0] recon_chan(input logic [7:0] delta,
			input logic [7:0] left, input logic [7:0] top,
			input logic first_row, input logic first_col);
		logic [8:0] sum;
		logic [7:0] pred;
		sum = {1'b0, left} + {1'b0, top};
		if (first_row && first_col) begin
			pred = 8'd0;
		end else if (first_row) begin
			pred = left;
		end else if (first_col) begin
			pred = top;
		end else begin
			pred = sum[8:1];
		end
		return delta + pred;
	endfunction

endpackage

// ===== rtl/apu_line_mem.sv =====
`timescale 1ns / 1ps
// previous-row line store: one write port, one registered read port
// no dependencies

module apu_line_mem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12,
	parameter int unsigned DW = 32
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// read returns the old entry when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/apu_pos.sv =====
`timescale 1ns / 1ps
// raster position counters: column and row with clamped width and height
// depends on apu_pkg

module apu_pos
	import apu_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned AW = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ROW_WIDTH_W-1:0] row_width,
	input  logic [HEIGHT_W-1:0]    frame_height,
	input  logic                   adv,
	output logic [AW-1:0]          col,
	output apu_pos_t               pos
);

	localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) : ROW_WIDTH_W;

	logic [AW-1:0]       col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [WW-1:0]       rw_x;
	logic [WW-1:0]       w_eff;
	logic [WW-1:0]       col_inc;
	logic [HEIGHT_W-1:0] h_eff;
	logic [HEIGHT_W:0]   row_inc;
	logic                last_col;
	logic                bottom_row;

	always_comb begin
		rw_x = WW'(row_width);
		if (rw_x == '0) begin
			w_eff = WW'(1);
		end else if (rw_x > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = rw_x;
		end
		h_eff = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
		col_inc = WW'(col_q) + WW'(1);
		row_inc = {1'b0, row_q} + (HEIGHT_W + 1)'(1);
		last_col = (col_inc >= w_eff);
		bottom_row = (row_inc >= {1'b0, h_eff});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= bottom_row ? '0 : row_inc[HEIGHT_W-1:0];
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign col = col_q;
	assign pos.first_row = (row_q == '0);
	assign pos.first_col = (col_q == '0);
	assign pos.last_col  = last_col;
	assign pos.frame_end = last_col & bottom_row;

endmodule

// ===== rtl/average_predictor_pixel_unfilter_top.sv =====
`timescale 1ns / 1ps
// average-predictor pixel unfilter, top level: config registers, pipeline, output register
// depends on apu_pkg, apu_pos, apu_line_mem
//
// usage
//   s_* stream: one residual pixel per request, tdata = delta_b, delta_g, delta_r, delta_a
//   (bits 7:0 up), in raster order. m_* stream: reconstructed red, green, blue, alpha
//   (bits 7:0 up), tlast marks the last pixel of a frame; the next pixel starts a new frame.
//   apb port: row_width at 0x0, frame_height at 0x4, four_channel at 0x8; write only
//   while the stream is idle.
// pipeline and throughput
//   a pixel goes from stage 1 to the output register. one pixel per clock sustained while
//   m_tready is high: the line store is read at accept and written as the pixel leaves
//   stage 1, on one single memory, with forwarding of the left pixel for one-wide rows.
// reset
//   arst_n clears the position (row 0, column 0), the left pixel, all valid flags and the
//   registers (row_width 1, frame_height 1, four_channel 1). the line store is not cleared:
//   row 0 does not use what it reads from it.
// stall
//   when m_tready is low the output register holds; one more pixel may sit in the
//   compute stage, after which s_tready goes low until the output is taken.

module average_predictor_pixel_unfilter_top
	import apu_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// residual pixels
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,  // delta_b, delta_g, delta_r, delta_a
	// reconstructed pixels
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // red, green, blue, alpha
	output logic              m_tlast   // frame_end
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	// config registers
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [HEIGHT_W-1:0]    frame_height_q;
	logic                   four_channel_q;
	logic                   cfg_wr;

	// stage 0 position
	logic [AW-1:0] col;
	apu_pos_t      pos;
	logic          s_acc;

	// stage 1: line store data arrives
	logic          valid_s1;
	logic [31:0]   delta_s1;  // reordered to r, g, b, a
	logic [AW-1:0] col_s1;
	apu_pos_t      pos_s1;
	logic          fwd_s1;
	logic          adv_s1;
	logic [31:0]   top_word;
	logic [31:0]   px;

	logic [31:0] left_q;
	logic [31:0] out_data_q;
	logic        out_last_q;
	logic        out_valid_q;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= ROW_WIDTH_W'(1);
			frame_height_q <= HEIGHT_W'(1);
			four_channel_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROW_WIDTH: begin
					row_width_q <= pwdata[ROW_WIDTH_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[HEIGHT_W-1:0];
				end
				REG_FOUR_CHANNEL: begin
					four_channel_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROW_WIDTH:    prdata = 32'(row_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_FOUR_CHANNEL: prdata = 32'(four_channel_q);
			default:          prdata = '0;
		endcase
	end

	// handshake: output register frees the compute stage, compute stage frees the input
	assign adv_s1   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;
	assign s_acc    = s_tvalid & s_tready;

	apu_pos #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_width    (row_width_q),
		.frame_height (frame_height_q),
		.adv          (s_acc),
		.col          (col),
		.pos          (pos)
	);

	// line store: read the top pixel at accept, write the new pixel as it leaves stage 1
	apu_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW),
		.DW    (32)
	) u_line (
		.clk     (clk),
		.rd_en   (s_acc),
		.rd_addr (col),
		.rd_data (top_word),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (px)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of stage 1; fwd_s1 marks a read that raced the write of the same column
	always_ff @(posedge clk) begin
		if (s_acc) begin
			delta_s1 <= {s_tdata[31:24], s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
			col_s1   <= col;
			pos_s1   <= pos;
			fwd_s1   <= valid_s1 & (col_s1 == col);
		end
	end

	// reconstruction, channels r, g, b, a from bit 0 up
	always_comb begin
		logic [31:0] top;
		top = fwd_s1 ? left_q : top_word;
		for (int k = 0; k < 4; k++) begin
			px[8*k +: 8] = recon_chan(delta_s1[8*k +: 8], left_q[8*k +: 8], top[8*k +: 8],
				pos_s1.first_row, pos_s1.first_col);
		end
		if (!four_channel_q) begin
			px[31:24] = ALPHA_OPAQUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (adv_s1) begin
			left_q <= px;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= px;
			out_last_q <= pos_s1.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// a pixel in stage 1 is never overwritten before it moves on
	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && valid_s1 |-> adv_s1)
		else $error("stage 1 pixel overwritten");

	// the last column of a row sends the next pixel to column 0
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && pos.last_col |=> col == '0)
		else $error("column did not wrap after last column");

	// a frame end is always a last column
	a_frame_end_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pos_s1.frame_end |-> pos_s1.last_col)
		else $error("frame end off the last column");

endmodule
